>>> src/rtcp_pkg.sv
package rtcp_pkg;

  localparam logic [63:0] GOLDEN64 = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] GOLDEN32 = 64'h000000009e3779b9;
  localparam logic [63:0] MIX_MUL1 = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_MUL2 = 64'h94d049bb133111eb;

  localparam int unsigned SHIFT_FIN1 = 30;
  localparam int unsigned SHIFT_FIN2 = 27;
  localparam int unsigned SHIFT_FIN3 = 31;
  localparam int unsigned SHIFT_OZ   = 11;
  localparam int unsigned SHIFT_OY   = 22;
  localparam int unsigned SHIFT_CL   = 6;
  localparam int unsigned SHIFT_CR   = 2;

  localparam logic [8:0]  CHUNK_SIZE_DEFAULT    = 9'd16;
  localparam logic [12:0] COLUMN_HEIGHT_DEFAULT = 13'd128;
  localparam logic [16:0] COUNT_MAX             = 17'h1ffff;

  localparam int unsigned MUL_DIGIT = 16;
  localparam int unsigned MUL_STEPS = 64 / MUL_DIGIT;

  localparam logic [2:0] REG_HASH_SEED     = 3'd0;
  localparam logic [2:0] REG_CHUNK_SIZE    = 3'd1;
  localparam logic [2:0] REG_COLUMN_HEIGHT = 3'd2;
  localparam logic [2:0] REG_CENTER_X      = 3'd3;
  localparam logic [2:0] REG_CENTER_Z      = 3'd4;
  localparam logic [2:0] REG_ACTIVE_RADIUS = 3'd5;
  localparam logic [2:0] REG_TICK_BUDGET   = 3'd6;

  typedef struct packed {
    logic signed [23:0] chunk_x;
    logic signed [23:0] chunk_z;
    logic [63:0]        tick_number;
    logic               pass_start;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] cell_x;
    logic [11:0]        cell_y;
    logic signed [31:0] cell_z;
  } out_word_t;

  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [12:0] divisor;
  } mod_req_t;

endpackage

>>> src/rtcp_mul.sv
module rtcp_mul (
  input  logic              clk,
  input  logic              rst,
  input  rtcp_pkg::mul_req_t req,
  output logic [63:0]       product,
  output logic              done
);
  import rtcp_pkg::*;

  logic [63:0] a_sh;
  logic [63:0] b_sh;
  logic [63:0] acc;
  logic [$clog2(MUL_STEPS)-1:0] cnt;
  logic        busy;
  logic [63+MUL_DIGIT:0] part;
  logic [63:0] acc_next;

  always_comb begin
    part     = a_sh * b_sh[MUL_DIGIT-1:0];
    acc_next = acc + part[63:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        a_sh <= req.a;
        b_sh <= req.b;
        acc  <= '0;
      end else if (busy) begin
        acc  <= acc_next;
        a_sh <= a_sh << MUL_DIGIT;
        b_sh <= b_sh >> MUL_DIGIT;
        cnt  <= cnt + 1'b1;
        if (cnt == $clog2(MUL_STEPS)'(MUL_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign product = acc;

endmodule

>>> src/rtcp_mod.sv
module rtcp_mod (
  input  logic              clk,
  input  logic              rst,
  input  rtcp_pkg::mod_req_t req,
  output logic [11:0]       remainder,
  output logic              done
);
  import rtcp_pkg::*;

  logic [63:0] num;
  logic [12:0] divisor;
  logic [12:0] rem;
  logic [5:0]  cnt;
  logic        busy;
  logic [13:0] trial;
  logic [13:0] diff;
  logic [12:0] rem_next;

  always_comb begin
    trial = {rem, num[63]};
    diff  = trial - {1'b0, divisor};
    rem_next = (trial >= {1'b0, divisor}) ? diff[12:0] : trial[12:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy    <= 1'b1;
        cnt     <= '0;
        num     <= req.dividend;
        divisor <= req.divisor;
        rem     <= '0;
      end else if (busy) begin
        rem <= rem_next;
        num <= num << 1;
        cnt <= cnt + 1'b1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign remainder = rem[11:0];

endmodule

>>> src/random_tick_cell_picker.sv
// A chunk word is carried through to its result before the next word is taken:
// in_ready is high only in S_IDLE, and S_OUT waits while the output is held.
// The work is three 64-step remainders, four 4-step multiplies and hash rounds;
// a skipped chunk returns to S_IDLE straight from the region check.
// Synchronous active-high reset: registers take their default values,
// the dispatch count clears and both channels go idle.
module random_tick_cell_picker (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rtcp_pkg::in_word_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output rtcp_pkg::out_word_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [63:0]          cfg_data
);
  import rtcp_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_COMB_A, S_COMB_B, S_FIN_ADD,
    S_M1, S_M1W, S_M2, S_M2W,
    S_DX, S_DXW, S_DZ, S_DZW, S_DY, S_DYW,
    S_MX, S_MXW, S_MZ, S_MZW, S_OUT
  } state_t;

  state_t state;

  logic [63:0]        hash_seed;
  logic [8:0]         chunk_size;
  logic [12:0]        column_height;
  logic signed [23:0] center_chunk_x;
  logic signed [23:0] center_chunk_z;
  logic signed [23:0] active_radius;
  logic signed [16:0] tick_budget;
  logic [16:0]        dispatched;

  logic signed [23:0] cx;
  logic signed [23:0] cz;
  logic [63:0]        tick;
  logic [63:0]        h;
  logic [63:0]        t;
  logic [1:0]         round;
  logic [11:0]        ox;
  logic [11:0]        oz;
  logic [11:0]        oy;
  logic [31:0]        bx;
  logic [31:0]        bz;

  mul_req_t    mul_req;
  mod_req_t    mod_req;
  logic [63:0] mul_product;
  logic        mul_done;
  logic [11:0] mod_rem;
  logic        mod_done;

  logic [8:0]  cs_eff;
  logic [12:0] ch_eff;
  logic [24:0] dx;
  logic [24:0] dz;
  logic [24:0] dmax;
  logic        active;
  logic        budget_hit;
  logic [63:0] comb_v;

  assign cs_eff = (chunk_size == '0) ? CHUNK_SIZE_DEFAULT : chunk_size;
  assign ch_eff = (column_height == '0) ? COLUMN_HEIGHT_DEFAULT : column_height;

  always_comb begin
    logic signed [24:0] ddx;
    logic signed [24:0] ddz;
    ddx  = 25'(cx) - 25'(center_chunk_x);
    ddz  = 25'(cz) - 25'(center_chunk_z);
    dx   = ddx[24] ? 25'(-ddx) : 25'(ddx);
    dz   = ddz[24] ? 25'(-ddz) : 25'(ddz);
    dmax = (dx > dz) ? dx : dz;
    if (center_chunk_x == -24'sd1) begin
      active = 1'b1;
    end else if (active_radius[23]) begin
      active = (dmax == '0);
    end else begin
      active = (dmax <= {1'b0, active_radius});
    end
    budget_hit = !tick_budget[16] && (dispatched >= {1'b0, tick_budget[15:0]});
  end

  always_comb begin
    case (round)
      2'd0:    comb_v = {32'b0, {8{cx[23]}}, cx};
      2'd1:    comb_v = {32'b0, {8{cz[23]}}, cz};
      default: comb_v = tick;
    endcase
  end

  always_comb begin
    mul_req = '0;
    mod_req = '0;
    case (state)
      S_M1: begin
        mul_req.start = 1'b1;
        mul_req.a     = h ^ (h >> SHIFT_FIN1);
        mul_req.b     = MIX_MUL1;
      end
      S_M2: begin
        mul_req.start = 1'b1;
        mul_req.a     = h ^ (h >> SHIFT_FIN2);
        mul_req.b     = MIX_MUL2;
      end
      S_MX: begin
        mul_req.start = 1'b1;
        mul_req.a     = {{40{cx[23]}}, cx};
        mul_req.b     = {55'b0, cs_eff};
      end
      S_MZ: begin
        mul_req.start = 1'b1;
        mul_req.a     = {{40{cz[23]}}, cz};
        mul_req.b     = {55'b0, cs_eff};
      end
      S_DX: begin
        mod_req.start    = 1'b1;
        mod_req.dividend = h;
        mod_req.divisor  = {4'b0, cs_eff};
      end
      S_DZ: begin
        mod_req.start    = 1'b1;
        mod_req.dividend = h >> SHIFT_OZ;
        mod_req.divisor  = {4'b0, cs_eff};
      end
      S_DY: begin
        mod_req.start    = 1'b1;
        mod_req.dividend = h >> SHIFT_OY;
        mod_req.divisor  = ch_eff;
      end
      default: begin
      end
    endcase
  end

  rtcp_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .req     (mul_req),
    .product (mul_product),
    .done    (mul_done)
  );

  rtcp_mod u_mod (
    .clk       (clk),
    .rst       (rst),
    .req       (mod_req),
    .remainder (mod_rem),
    .done      (mod_done)
  );

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      out_valid      <= 1'b0;
      dispatched     <= '0;
      round          <= '0;
      hash_seed      <= '0;
      chunk_size     <= CHUNK_SIZE_DEFAULT;
      column_height  <= COLUMN_HEIGHT_DEFAULT;
      center_chunk_x <= -24'sd1;
      center_chunk_z <= '0;
      active_radius  <= '0;
      tick_budget    <= -17'sd1;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_HASH_SEED:     hash_seed      <= cfg_data;
          REG_CHUNK_SIZE:    chunk_size     <= cfg_data[8:0];
          REG_COLUMN_HEIGHT: column_height  <= cfg_data[12:0];
          REG_CENTER_X:      center_chunk_x <= cfg_data[23:0];
          REG_CENTER_Z:      center_chunk_z <= cfg_data[23:0];
          REG_ACTIVE_RADIUS: active_radius  <= cfg_data[23:0];
          REG_TICK_BUDGET:   tick_budget    <= cfg_data[16:0];
          default: begin
          end
        endcase
      end
      if (out_valid && out_ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cx    <= in_data.chunk_x;
            cz    <= in_data.chunk_z;
            tick  <= in_data.tick_number;
            h     <= hash_seed ^ GOLDEN64;
            round <= '0;
            if (in_data.pass_start) begin
              dispatched <= '0;
            end
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          state <= (active && !budget_hit) ? S_COMB_A : S_IDLE;
        end
        S_COMB_A: begin
          t     <= (h << SHIFT_CL) + (h >> SHIFT_CR);
          state <= S_COMB_B;
        end
        S_COMB_B: begin
          h <= h ^ (t + comb_v + GOLDEN32);
          if (round == 2'd2) begin
            state <= S_FIN_ADD;
          end else begin
            round <= round + 1'b1;
            state <= S_COMB_A;
          end
        end
        S_FIN_ADD: begin
          h     <= h + GOLDEN64;
          state <= S_M1;
        end
        S_M1: state <= S_M1W;
        S_M1W: begin
          if (mul_done) begin
            h     <= mul_product;
            state <= S_M2;
          end
        end
        S_M2: state <= S_M2W;
        S_M2W: begin
          if (mul_done) begin
            h     <= mul_product ^ (mul_product >> SHIFT_FIN3);
            state <= S_DX;
          end
        end
        S_DX: state <= S_DXW;
        S_DXW: begin
          if (mod_done) begin
            ox    <= mod_rem;
            state <= S_DZ;
          end
        end
        S_DZ: state <= S_DZW;
        S_DZW: begin
          if (mod_done) begin
            oz    <= mod_rem;
            state <= S_DY;
          end
        end
        S_DY: state <= S_DYW;
        S_DYW: begin
          if (mod_done) begin
            oy    <= mod_rem;
            state <= S_MX;
          end
        end
        S_MX: state <= S_MXW;
        S_MXW: begin
          if (mul_done) begin
            bx    <= mul_product[31:0] + {20'b0, ox};
            state <= S_MZ;
          end
        end
        S_MZ: state <= S_MZW;
        S_MZW: begin
          if (mul_done) begin
            bz    <= mul_product[31:0] + {20'b0, oz};
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_data.cell_x <= bx;
            out_data.cell_y <= oy;
            out_data.cell_z <= bz;
            out_valid       <= 1'b1;
            if (dispatched != COUNT_MAX) begin
              dispatched <= dispatched + 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // multiplies end in wait states; S_OUT loads a result once the old word is gone
  a_mul_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (state == S_M1W || state == S_M2W || state == S_MXW || state == S_MZW))
    else $error("multiply finished outside a wait state");

  a_mod_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    mod_done |-> (state == S_DXW || state == S_DZW || state == S_DYW))
    else $error("remainder finished outside a wait state");

  a_accept_to_check: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_CHECK))
    else $error("accepted word did not reach the region check");

  a_out_blocked_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && out_valid && !out_ready) |=> (state == S_OUT && out_valid))
    else $error("result register overwritten while occupied");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && (!out_valid || out_ready) && dispatched != COUNT_MAX)
      |=> (dispatched == $past(dispatched) + 17'd1))
    else $error("dispatch count did not advance on a result");

endmodule
